// ----- sv/rhss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seen-set package
// Sizes, request opcodes and shared types of the Robin Hood seen set.
// ----------------------------------------------------------------------------
package rhss_pkg;

   // Table geometry. SLOTS must be a power of two.
   localparam int SLOTS      = 1024;
   localparam int KEY_BITS   = 64;
   localparam int INDEX_BITS = $clog2(SLOTS);
   localparam int COUNT_BITS = $clog2(SLOTS + 1);

   // Probe limit and distance widths.
   localparam int MAX_PROBE  = 128;
   localparam int LIMIT_BITS = 8;
   localparam int DIST_BITS  = 7;
   localparam int OP_BITS    = 2;
   localparam int PORT_KEY_BITS = 64;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(MAX_PROBE);

   // Request opcodes; the fourth code does nothing.
   localparam logic [OP_BITS-1:0] OP_INSERT    = 2'd0;
   localparam logic [OP_BITS-1:0] OP_CONTAINS  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_MARK_DONE = 2'd2;

   // One table slot as held in the slot memory.
   typedef struct packed {
      logic                  valid;
      logic                  done;
      logic [DIST_BITS-1:0]  distance;
      logic [KEY_BITS-1:0]   key;
   } slot_type;

   // Verdict of the probe unit for one slot.
   typedef struct packed {
      logic is_free;
      logic match;
      logic stop;
      logic swap;
   } probe_result_type;

endpackage

// ----- sv/rhss_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seen-set request channel
// Valid/ready channel that carries an opcode and a key.
// ----------------------------------------------------------------------------
interface rhss_req_if;
   logic                               valid;
   logic                               ready;
   logic [rhss_pkg::OP_BITS-1:0]       op;
   logic [rhss_pkg::PORT_KEY_BITS-1:0] key;

   modport source (output valid, output op, output key, input ready);
   modport sink (input valid, input op, input key, output ready);
endinterface

// ----- sv/rhss_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seen-set response channel
// Valid/ready channel that carries the answer, the full flag and the count.
// ----------------------------------------------------------------------------
interface rhss_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            answer;
   logic                            table_full;
   logic [rhss_pkg::COUNT_BITS-1:0] entry_count;

   modport source (output valid, output answer, output table_full,
                   output entry_count, input ready);
   modport sink (input valid, input answer, input table_full,
                 input entry_count, output ready);
endinterface

// ----- sv/rhss_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rhss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- sv/rhss_probe_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seen-set probe unit
// Compares one slot against the searched key and the carried entry.
// ----------------------------------------------------------------------------
module rhss_probe_unit (
   input  rhss_pkg::slot_type                  slot,
   input  logic                                is_insert,
   input  logic                                swapped,
   input  logic [rhss_pkg::KEY_BITS-1:0]       search_key,
   input  logic [rhss_pkg::DIST_BITS-1:0]      carry_dist,
   input  logic [rhss_pkg::LIMIT_BITS-1:0]     step,
   output rhss_pkg::probe_result_type          result
);
   import rhss_pkg::*;

   logic key_equal;
   logic hit;

   // Key compare; after a swap an insert no longer looks for its own key.
   assign key_equal = (slot.key == search_key);
   assign hit       = slot.valid && key_equal && (!is_insert || !swapped);

   // A lookup ends when the stored entry lies nearer its home than the probe step.
   always_comb begin
      result.is_free = !slot.valid;
      result.match   = hit;
      result.stop    = !is_insert && slot.valid && !hit &&
                       (step > LIMIT_BITS'(slot.distance));
      result.swap    = is_insert && slot.valid && !hit && (carry_dist > slot.distance);
   end

endmodule

// ----- sv/robin_hood_seen_set.sv -----
// Each probe reads a slot memory word (ST_READ) and compares it (ST_EVAL);
// a new insert walks twice (check pass, then write pass). Requests are taken
// one at a time: the sequencer takes a new request only after ST_RESP has
// registered the response. After reset a clearing pass over all SLOTS (1024)
// slots runs first.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robin Hood seen set
// Set of hash keys in a linear-probing Robin Hood table with insert,
// contains and mark-done requests, walked one slot at a time.
// ----------------------------------------------------------------------------
module robin_hood_seen_set (
   input  logic                            clock,
   input  logic                            reset,
   rhss_req_if.sink                        req,
   rhss_rsp_if.source                      rsp,
   input  logic                            csr_write_enable,
   input  logic [rhss_pkg::LIMIT_BITS-1:0] csr_write_data
);
   import rhss_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_EVAL  = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [INDEX_BITS-1:0]   clear_ff, clear_in;
   logic [LIMIT_BITS-1:0]   limit_ff, limit_in;
   logic [LIMIT_BITS-1:0]   lim_ff, lim_in;
   logic [OP_BITS-1:0]      op_ff, op_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [INDEX_BITS-1:0]   idx_ff, idx_in;
   logic [LIMIT_BITS-1:0]   step_ff, step_in;
   logic                    commit_ff, commit_in;
   logic                    swapped_ff, swapped_in;
   logic [KEY_BITS-1:0]     carry_key_ff, carry_key_in;
   logic                    carry_done_ff, carry_done_in;
   logic [DIST_BITS-1:0]    carry_dist_ff, carry_dist_in;
   logic                    answer_ff, answer_in;
   logic                    full_ff, full_in;
   logic [COUNT_BITS-1:0]   entry_count_ff, entry_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_answer_ff, rsp_answer_in;
   logic                    rsp_full_ff, rsp_full_in;
   logic [COUNT_BITS-1:0]   rsp_count_ff, rsp_count_in;

   logic                    ram_wr_en;
   logic [INDEX_BITS-1:0]   ram_wr_addr;
   slot_type                ram_wr_data;
   logic                    ram_rd_en;
   slot_type                rd_slot;
   probe_result_type        probe;
   logic                    is_insert;
   logic                    last_step;
   logic [LIMIT_BITS-1:0]   lim_eff;
   logic [KEY_BITS-1:0]     req_key_masked;
   slot_type                carry_slot;

   // Slot memory: key, done bit, distance and valid bit in one word.
   rhss_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_slot)
   );

   // Shared compare unit for every probe step.
   rhss_probe_unit u_probe (
      .slot       (rd_slot),
      .is_insert  (is_insert),
      .swapped    (swapped_ff),
      .search_key (key_ff),
      .carry_dist (carry_dist_ff),
      .step       (step_ff),
      .result     (probe)
   );

   assign is_insert      = (op_ff == OP_INSERT);
   assign last_step      = (step_ff == lim_ff - LIMIT_BITS'(1));
   assign req_key_masked = req.key[KEY_BITS-1:0];
   assign ram_rd_en      = (state_ff == ST_READ);

   // The carried entry as it would be written into a slot.
   always_comb begin
      carry_slot.valid    = 1'b1;
      carry_slot.done     = carry_done_ff;
      carry_slot.distance = carry_dist_ff;
      carry_slot.key      = carry_key_ff;
   end

   // Effective probe limit: at least one, at most MAX_PROBE and the table size.
   always_comb begin
      lim_eff = limit_ff;
      if (lim_eff == '0) begin
         lim_eff = LIMIT_BITS'(1);
      end
      if (lim_eff > LIMIT_BITS'(MAX_PROBE)) begin
         lim_eff = LIMIT_BITS'(MAX_PROBE);
      end
      if (SLOTS < MAX_PROBE && lim_eff > LIMIT_BITS'(SLOTS)) begin
         lim_eff = LIMIT_BITS'(SLOTS);
      end
   end

   // Configuration register.
   assign limit_in = csr_write_enable ? csr_write_data : limit_ff;

   // Sequencer: clearing pass, request intake, probe walk and response.
   always_comb begin
      state_in      = state_ff;
      clear_in      = clear_ff;
      lim_in        = lim_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      commit_in     = commit_ff;
      swapped_in    = swapped_ff;
      carry_key_in  = carry_key_ff;
      carry_done_in = carry_done_ff;
      carry_dist_in = carry_dist_ff;
      answer_in     = answer_ff;
      full_in       = full_ff;
      entry_count_in = entry_count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff;
      ram_wr_data   = carry_slot;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_answer_in = rsp_answer_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clear_ff;
            ram_wr_data = '0;
            clear_in    = clear_ff + INDEX_BITS'(1);
            if (clear_ff == INDEX_BITS'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req.valid) begin
               op_in         = req.op;
               key_in        = req_key_masked;
               lim_in        = lim_eff;
               idx_in        = req_key_masked[INDEX_BITS-1:0];
               step_in       = '0;
               commit_in     = 1'b0;
               swapped_in    = 1'b0;
               carry_key_in  = req_key_masked;
               carry_done_in = 1'b0;
               carry_dist_in = '0;
               answer_in     = 1'b0;
               full_in       = 1'b0;
               if (req.op == OP_INSERT || req.op == OP_CONTAINS ||
                   req.op == OP_MARK_DONE) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end

         ST_READ: begin
            state_in = ST_EVAL;
         end

         ST_EVAL: begin
            if (is_insert) begin
               if (probe.is_free) begin
                  if (commit_ff) begin
                     // Write pass: the carried entry lands in the free slot.
                     ram_wr_en      = 1'b1;
                     entry_count_in = entry_count_ff + COUNT_BITS'(1);
                     answer_in      = 1'b1;
                     state_in       = ST_RESP;
                  end else begin
                     // Check pass succeeded: walk again from home, writing.
                     commit_in     = 1'b1;
                     idx_in        = key_ff[INDEX_BITS-1:0];
                     step_in       = '0;
                     swapped_in    = 1'b0;
                     carry_key_in  = key_ff;
                     carry_done_in = 1'b0;
                     carry_dist_in = '0;
                     state_in      = ST_READ;
                  end
               end else if (probe.match) begin
                  state_in = ST_RESP;
               end else begin
                  if (probe.swap) begin
                     ram_wr_en     = commit_ff;
                     swapped_in    = 1'b1;
                     carry_key_in  = rd_slot.key;
                     carry_done_in = rd_slot.done;
                  end
                  if (last_step) begin
                     full_in  = 1'b1;
                     state_in = ST_RESP;
                  end else begin
                     idx_in        = idx_ff + INDEX_BITS'(1);
                     step_in       = step_ff + LIMIT_BITS'(1);
                     carry_dist_in = (probe.swap ? rd_slot.distance : carry_dist_ff)
                                     + DIST_BITS'(1);
                     state_in      = ST_READ;
                  end
               end
            end else begin
               if (probe.match) begin
                  answer_in = 1'b1;
                  // Mark done rewrites the found slot with its done bit set.
                  if (op_ff == OP_MARK_DONE) begin
                     ram_wr_en        = 1'b1;
                     ram_wr_data      = rd_slot;
                     ram_wr_data.done = 1'b1;
                  end
                  state_in = ST_RESP;
               end else if (probe.is_free || probe.stop || last_step) begin
                  state_in = ST_RESP;
               end else begin
                  idx_in   = idx_ff + INDEX_BITS'(1);
                  step_in  = step_ff + LIMIT_BITS'(1);
                  state_in = ST_READ;
               end
            end
         end

         ST_RESP: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = answer_ff;
               rsp_full_in   = full_ff;
               rsp_count_in  = entry_count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
            clear_in = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clear_ff       <= '0;
         limit_ff       <= LIMIT_RESET;
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clear_ff       <= clear_in;
         limit_ff       <= limit_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Walk and payload registers.
   always_ff @(posedge clock) begin
      lim_ff        <= lim_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      step_ff       <= step_in;
      commit_ff     <= commit_in;
      swapped_ff    <= swapped_in;
      carry_key_ff  <= carry_key_in;
      carry_done_ff <= carry_done_in;
      carry_dist_ff <= carry_dist_in;
      answer_ff     <= answer_in;
      full_ff       <= full_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Channel outputs.
   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.answer      = rsp_answer_ff;
   assign rsp.table_full  = rsp_full_ff;
   assign rsp.entry_count = rsp_count_ff;

   // No request is taken while the clearing pass runs.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req.ready)
      else $error("request accepted during clearing pass");

   // The entry count only ever grows by one at a time.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && entry_count_ff != $past(entry_count_ff)) |->
      (entry_count_ff == $past(entry_count_ff) + COUNT_BITS'(1)))
      else $error("entry count changed by other than one");

   // A full table never reports a newly added key.
   a_full_no_answer: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.answer && rsp.table_full))
      else $error("table full reported together with an answer");

   // The probe step stays below the effective limit.
   a_step_in_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> (step_ff < lim_ff))
      else $error("probe step beyond limit");

endmodule
